FILE: src/evs_pkg.sv
`default_nettype none

package evs_pkg;

  // Default coordinate width (signed Q16.16 at 32 bits)
  localparam int unsigned COORD_BITS_DEF = 32;

  // Six tracked extremes
  localparam int unsigned NUM_TRACK = 6;
  localparam int unsigned NUM_AXIS  = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } evs_reg_e;

  // Result kind, also the emission order
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOW_X  = 3'd0,
    KIND_HIGH_X = 3'd1,
    KIND_LOW_Y  = 3'd2,
    KIND_HIGH_Y = 3'd3,
    KIND_LOW_Z  = 3'd4,
    KIND_HIGH_Z = 3'd5
  } evs_kind_e;

  // Control from the top level to each tracker
  typedef struct packed {
    logic seed;    // first vertex of a mesh: load unconditionally
    logic update;  // later vertex: apply the limit/tie rules
  } evs_trk_ctrl_t;

endpackage

`default_nettype wire

FILE: src/evs_tracker.sv
`default_nettype none

// One tracked extreme point: holds the point and computes its next value
module evs_tracker #(
  parameter int unsigned W       = evs_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS    = 0,
  parameter bit          IS_HIGH = 1'b0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire evs_pkg::evs_trk_ctrl_t ctrl_i,
  input  wire logic [W-1:0]          vx_i,
  input  wire logic [W-1:0]          vy_i,
  input  wire logic [W-1:0]          vz_i,
  input  wire logic [W-1:0]          limit_i,
  output logic      [W-1:0]          nx_o,
  output logic      [W-1:0]          ny_o,
  output logic      [W-1:0]          nz_o
);

  // Secondary axes used to break a tie on the primary axis
  localparam int unsigned S1 = (AXIS == 0) ? 1 : 0;
  localparam int unsigned S2 = (AXIS == 2) ? 1 : 2;

  logic signed [W-1:0] pv [evs_pkg::NUM_AXIS];
  logic signed [W-1:0] tv [evs_pkg::NUM_AXIS];
  logic [W-1:0] trk_x_q, trk_y_q, trk_z_q;
  logic signed [W-1:0] lim;
  logic beyond, tie, better1, better2, take;

  assign pv[0] = vx_i;
  assign pv[1] = vy_i;
  assign pv[2] = vz_i;
  assign tv[0] = trk_x_q;
  assign tv[1] = trk_y_q;
  assign tv[2] = trk_z_q;
  assign lim   = limit_i;

  // Limit test, tie test and secondary comparisons
  always_comb begin
    if (IS_HIGH) begin
      beyond  = pv[AXIS] >= lim;
      better1 = pv[S1] > tv[S1];
      better2 = pv[S2] > tv[S2];
    end else begin
      beyond  = pv[AXIS] <= lim;
      better1 = pv[S1] < tv[S1];
      better2 = pv[S2] < tv[S2];
    end
    tie  = pv[AXIS] == tv[AXIS];
    take = ctrl_i.seed | (ctrl_i.update & beyond & (~tie | better1 | better2));
  end

  assign nx_o = take ? vx_i : trk_x_q;
  assign ny_o = take ? vy_i : trk_y_q;
  assign nz_o = take ? vz_i : trk_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_x_q <= '0;
      trk_y_q <= '0;
      trk_z_q <= '0;
    end else begin
      trk_x_q <= nx_o;
      trk_y_q <= ny_o;
      trk_z_q <= nz_o;
    end
  end

endmodule

`default_nettype wire

FILE: src/extreme_vertex_selector.sv
// Extreme vertex selector. Vertices stream in one per cycle (signed Q16.16
// coordinates); the first vertex of a mesh seeds six trackers (low/high x,
// y, z) and later vertices replace a tracker when they lie at or beyond the
// configured box limit on its axis, a tie on that axis needing a strictly
// better secondary coordinate. A request enters an input register and is
// applied from there to all six trackers while not held. On the vertex
// flagged last, the six points are copied into a result buffer and drained
// one per cycle in kind order 0..5 while the receiver does not stall, the
// sixth flagged final_result. Throughput is one vertex per cycle; the only
// wait is a last vertex arriving while the previous mesh's six results are
// still draining. Box registers may only be written while the block is
// idle.
`default_nettype none

module extreme_vertex_selector #(
  parameter int unsigned COORD_BITS = evs_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [evs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]         cfg_wdata_i,
  // vertex requests
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [COORD_BITS-1:0]         vertex_x_i,
  input  wire logic [COORD_BITS-1:0]         vertex_y_i,
  input  wire logic [COORD_BITS-1:0]         vertex_z_i,
  input  wire logic                          last_vertex_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [evs_pkg::KIND_W-1:0]         extreme_kind_o,
  output logic [COORD_BITS-1:0]              point_x_o,
  output logic [COORD_BITS-1:0]              point_y_o,
  output logic [COORD_BITS-1:0]              point_z_o,
  output logic                               final_result_o
);

  localparam int unsigned NT = evs_pkg::NUM_TRACK;
  localparam int unsigned NA = evs_pkg::NUM_AXIS;

  // Box limit registers
  logic [COORD_BITS-1:0] box_min_q [NA];
  logic [COORD_BITS-1:0] box_max_q [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        evs_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_wdata_i;
        evs_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        evs_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        evs_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_wdata_i;
        evs_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        evs_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Input register
  logic                  in_vld_q, in_last_q;
  logic [COORD_BITS-1:0] in_x_q, in_y_q, in_z_q;

  // Result buffer: entry 0 is presented, shifted down on each accept
  logic                  out_vld_q;
  evs_pkg::evs_kind_e    out_kind_q;
  logic [COORD_BITS-1:0] buf_x_q [NT];
  logic [COORD_BITS-1:0] buf_y_q [NT];
  logic [COORD_BITS-1:0] buf_z_q [NT];

  logic seeded_q;
  logic out_take, drain_free, blocked, step;
  evs_pkg::evs_trk_ctrl_t trk_ctrl;
  logic [COORD_BITS-1:0] nx [NT];
  logic [COORD_BITS-1:0] ny [NT];
  logic [COORD_BITS-1:0] nz [NT];

  // Flow control: only a last vertex waits, for the result buffer
  assign out_take   = out_vld_q & ~out_stall_i;
  assign drain_free = ~out_vld_q | (out_take & (out_kind_q == evs_pkg::KIND_HIGH_Z));
  assign blocked    = in_last_q & ~drain_free;
  assign step       = in_vld_q & ~blocked;
  assign in_stall_o = in_vld_q & blocked;

  assign trk_ctrl.seed   = step & ~seeded_q;
  assign trk_ctrl.update = step & seeded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_x_q    <= vertex_x_i;
      in_y_q    <= vertex_y_i;
      in_z_q    <= vertex_z_i;
      in_last_q <= last_vertex_i;
    end
  end

  // Seed flag: set after the first vertex, re-armed by the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (step) begin
      seeded_q <= ~in_last_q;
    end
  end

  // Six trackers in parallel
  for (genvar k = 0; k < NT; k++) begin : g_trk
    localparam int unsigned AX = k / 2;
    localparam bit          HI = (k % 2) == 1;

    evs_tracker #(
      .W       (COORD_BITS),
      .AXIS    (AX),
      .IS_HIGH (HI)
    ) u_trk (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (trk_ctrl),
      .vx_i    (in_x_q),
      .vy_i    (in_y_q),
      .vz_i    (in_z_q),
      .limit_i (HI ? box_max_q[AX] : box_min_q[AX]),
      .nx_o    (nx[k]),
      .ny_o    (ny[k]),
      .nz_o    (nz[k])
    );
  end

  // Result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_kind_q <= evs_pkg::KIND_LOW_X;
    end else if (step && in_last_q) begin
      out_vld_q  <= 1'b1;
      out_kind_q <= evs_pkg::KIND_LOW_X;
    end else if (out_take) begin
      if (out_kind_q == evs_pkg::KIND_HIGH_Z) begin
        out_vld_q <= 1'b0;
      end else begin
        out_kind_q <= evs_pkg::evs_kind_e'(out_kind_q + 3'd1);
      end
    end
  end

  // Result buffer data: snapshot of the updated trackers, or shift
  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      for (int i = 0; i < NT; i++) begin
        buf_x_q[i] <= nx[i];
        buf_y_q[i] <= ny[i];
        buf_z_q[i] <= nz[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < NT - 1; i++) begin
        buf_x_q[i] <= buf_x_q[i+1];
        buf_y_q[i] <= buf_y_q[i+1];
        buf_z_q[i] <= buf_z_q[i+1];
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign extreme_kind_o = out_kind_q;
  assign point_x_o      = buf_x_q[0];
  assign point_y_o      = buf_y_q[0];
  assign point_z_o      = buf_z_q[0];
  assign final_result_o = out_kind_q == evs_pkg::KIND_HIGH_Z;

endmodule

`default_nettype wire

FILE: src/evs_checker.sv
`default_nettype none

module evs_checker #(
  parameter int unsigned COORD_BITS = evs_pkg::COORD_BITS_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      last_vertex_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [evs_pkg::KIND_W-1:0] extreme_kind_o,
  input wire logic [COORD_BITS-1:0]     point_x_o,
  input wire logic                      final_result_o
);

  // Final flag marks exactly the high-z result
  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_result_o == (extreme_kind_o == evs_pkg::KIND_HIGH_Z)))
    else $error("final_result does not match result kind");

  // Within a mesh, results follow back to back in kind order
  a_kind_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !final_result_o) |=>
      (out_valid_o && extreme_kind_o == $past(extreme_kind_o) + 3'd1))
    else $error("result sequence broken");

  // A new mesh always starts at low x
  a_kind_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && final_result_o) |=>
      (!out_valid_o || extreme_kind_o == evs_pkg::KIND_LOW_X))
    else $error("mesh results do not start at low x");

  // Results appear only after a last vertex was taken
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_vertex_i, 2))
    else $error("results without a last vertex");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(extreme_kind_o) && $stable(point_x_o)))
    else $error("stalled result changed");

endmodule

bind extreme_vertex_selector evs_checker #(
  .COORD_BITS (COORD_BITS)
) u_evs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_vertex_i  (last_vertex_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .extreme_kind_o (extreme_kind_o),
  .point_x_o      (point_x_o),
  .final_result_o (final_result_o)
);

`default_nettype wire

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW            = evs_pkg::COORD_BITS_DEF;
  localparam int ONE           = 65536;  // 1.0 in Q16.16
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 250;
  localparam int MAX_REPORTS   = 10;

  // Indexes past the last box register; writes there must be dropped
  localparam logic [evs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [evs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t MAX_C = {1'b0, {(CW-1){1'b1}}};

  typedef enum int {
    BOX_ZERO,
    BOX_OPEN,
    BOX_CLOSED,
    BOX_WIDE,
    BOX_NEAR,
    BOX_MODES
  } box_mode_e;

  typedef struct packed {
    evs_pkg::evs_kind_e kind;
    coord_t             px;
    coord_t             py;
    coord_t             pz;
    logic               closing;
  } point_rec_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [evs_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CW-1:0]                 cfg_wdata_i   = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic [CW-1:0]                 vertex_x_i    = '0;
  logic [CW-1:0]                 vertex_y_i    = '0;
  logic [CW-1:0]                 vertex_z_i    = '0;
  logic                          last_vertex_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [evs_pkg::KIND_W-1:0]    extreme_kind_o;
  logic [CW-1:0]                 point_x_o;
  logic [CW-1:0]                 point_y_o;
  logic [CW-1:0]                 point_z_o;
  logic                          final_result_o;

  extreme_vertex_selector #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_z_i    (vertex_z_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .extreme_kind_o(extreme_kind_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .final_result_o(final_result_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: box limits, tracked points, seed flag
  coord_t     box_lim [evs_pkg::NUM_TRACK] = '{default: '0};
  coord_t     pt_x [evs_pkg::NUM_TRACK];
  coord_t     pt_y [evs_pkg::NUM_TRACK];
  coord_t     pt_z [evs_pkg::NUM_TRACK];
  bit         mesh_open = 1'b0;
  point_rec_t pending_points [$];

  int mismatch_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int box_rotor    = 0;

  // Strictly better: smaller for a low tracker, larger for a high one
  function automatic bit beats(coord_t a, coord_t b, bit high);
    return high ? (a > b) : (a < b);
  endfunction

  // Apply one accepted vertex to the shadow trackers and queue the six
  // points when it closes the mesh
  function automatic void track_vertex(coord_t vx, coord_t vy, coord_t vz, bit last);
    coord_t     p [3];
    coord_t     t [3];
    coord_t     lim;
    int         axis;
    int         s1;
    int         s2;
    bit         high;
    bit         beyond;
    point_rec_t rec;
    p = '{vx, vy, vz};
    if (!mesh_open) begin
      for (int k = 0; k < evs_pkg::NUM_TRACK; k++) begin
        pt_x[k] = vx;
        pt_y[k] = vy;
        pt_z[k] = vz;
      end
      mesh_open = 1'b1;
    end else begin
      for (int k = 0; k < evs_pkg::NUM_TRACK; k++) begin
        axis   = k / 2;
        high   = (k % 2) != 0;
        s1     = (axis == 0) ? 1 : 0;
        s2     = (axis == 2) ? 1 : 2;
        lim    = box_lim[(high ? int'(evs_pkg::REG_BOX_MAX_X)
                               : int'(evs_pkg::REG_BOX_MIN_X)) + axis];
        t      = '{pt_x[k], pt_y[k], pt_z[k]};
        beyond = high ? (p[axis] >= lim) : (p[axis] <= lim);
        // a tie on the own axis needs a strictly better secondary coordinate
        if (beyond && (p[axis] != t[axis] || beats(p[s1], t[s1], high) ||
                       beats(p[s2], t[s2], high))) begin
          pt_x[k] = vx;
          pt_y[k] = vy;
          pt_z[k] = vz;
        end
      end
    end
    if (last) begin
      for (int k = 0; k < evs_pkg::NUM_TRACK; k++) begin
        rec.kind    = evs_pkg::evs_kind_e'(k);
        rec.px      = pt_x[k];
        rec.py      = pt_y[k];
        rec.pz      = pt_z[k];
        rec.closing = (k == evs_pkg::NUM_TRACK - 1);
        pending_points = {pending_points, rec};
      end
      mesh_open = 1'b0;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_results
    point_rec_t want;
    point_rec_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind    = evs_pkg::evs_kind_e'(extreme_kind_o);
      got.px      = point_x_o;
      got.py      = point_y_o;
      got.pz      = point_z_o;
      got.closing = final_result_o;
      if (pending_points.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: kind %0d x %h y %h z %h final %b",
                   got.kind, got.px, got.py, got.pz, got.closing);
      end else begin
        want = pending_points.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d x %h y %h z %h final %b",
                     want.kind, want.px, want.py, want.pz, want.closing);
            $display("          actual   kind %0d x %h y %h z %h final %b",
                     got.kind, got.px, got.py, got.pz, got.closing);
          end
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Offer one vertex request and hold it until accepted
  task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t vz,
                             input bit last);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i    <= 1'b1;
    vertex_x_i    <= vx;
    vertex_y_i    <= vy;
    vertex_z_i    <= vz;
    last_vertex_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    track_vertex(vx, vy, vz, last);
  endtask

  // Stop offering and wait until every queued point has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Program all six box limits, optionally poking the unused indexes first
  task automatic write_box(input coord_t lim [evs_pkg::NUM_TRACK], input bit spare_too);
    if (spare_too) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_SPARE_LO;
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
      cfg_idx_i   <= CFG_IDX_SPARE_HI;
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
    end
    for (int i = evs_pkg::REG_BOX_MIN_X; i <= evs_pkg::REG_BOX_MAX_Z; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= evs_pkg::CFG_IDX_W'(i);
      cfg_wdata_i <= lim[i];
      @(posedge clk_i);
      box_lim[i] = lim[i];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void pick_box(input box_mode_e mode,
                                   output coord_t lim [evs_pkg::NUM_TRACK]);
    for (int a = 0; a < evs_pkg::NUM_AXIS; a++) begin
      case (mode)
        BOX_ZERO: begin
          lim[a] = '0;
          lim[a + evs_pkg::NUM_AXIS] = '0;
        end
        BOX_OPEN: begin
          lim[a] = MAX_C;
          lim[a + evs_pkg::NUM_AXIS] = MIN_C;
        end
        BOX_CLOSED: begin
          lim[a] = MIN_C;
          lim[a + evs_pkg::NUM_AXIS] = MAX_C;
        end
        BOX_WIDE: begin
          lim[a] = $urandom;
          lim[a + evs_pkg::NUM_AXIS] = $urandom;
        end
        default: begin
          lim[a] = (int'($urandom_range(6)) - 3) * ONE;
          lim[a + evs_pkg::NUM_AXIS] = (int'($urandom_range(6)) - 3) * ONE;
        end
      endcase
    end
  endfunction

  // Coordinate mix: full range, small grid values for ties, extremes, limits
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5, 6:    return coord_t'((int'($urandom_range(6)) - 3) * ONE);
      7:          return coord_t'(int'($urandom_range(4)) - 2);
      8:          return $urandom_range(1) ? MAX_C : MIN_C;
      default:    return box_lim[$urandom_range(evs_pkg::NUM_TRACK - 1)];
    endcase
  endfunction

  // One mesh of n vertices; fields often repeat the previous vertex
  task automatic send_mesh(input int n);
    coord_t vx;
    coord_t vy;
    coord_t vz;
    vx = rand_coord();
    vy = rand_coord();
    vz = rand_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) vx = rand_coord();
      if ($urandom_range(3) != 0) vy = rand_coord();
      if ($urandom_range(3) != 0) vz = rand_coord();
      send_vertex(vx, vy, vz, i == n - 1);
    end
  endtask

  // Single vertex meshes back to back, reset box
  task automatic test_single_vertex();
    send_vertex(MIN_C, MAX_C, '0, 1'b1);
    send_vertex(MAX_C, MIN_C, MIN_C, 1'b1);
    send_vertex('0, '0, MAX_C, 1'b1);
  endtask

  // Open box: plain extreme tracking over the full coordinate range
  task automatic test_open_box();
    coord_t lim [evs_pkg::NUM_TRACK];
    wait_idle();
    pick_box(BOX_OPEN, lim);
    write_box(lim, 1'b0);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(MIN_C, MAX_C, MIN_C, 1'b0);
    send_vertex(MAX_C, MIN_C, MAX_C, 1'b0);
    send_vertex(1, -1, 1, 1'b1);
  endtask

  // Ties on the tracked axis resolved by the secondary coordinates
  task automatic test_axis_ties();
    send_vertex(5 * ONE, 5 * ONE, 5 * ONE, 1'b0);
    send_vertex(5 * ONE, 4 * ONE, 5 * ONE, 1'b0);
    send_vertex(5 * ONE, 5 * ONE, 4 * ONE, 1'b0);
    send_vertex(5 * ONE, 6 * ONE, 5 * ONE, 1'b0);
    send_vertex(5 * ONE, 5 * ONE, 6 * ONE, 1'b0);
    send_vertex(5 * ONE, 4 * ONE, 6 * ONE, 1'b1);
  endtask

  // Vertices at, inside and beyond a +-10 box; writes to unused indexes
  task automatic test_box_limits();
    coord_t lim [evs_pkg::NUM_TRACK];
    wait_idle();
    for (int a = 0; a < evs_pkg::NUM_AXIS; a++) begin
      lim[a] = -10 * ONE;
      lim[a + evs_pkg::NUM_AXIS] = 10 * ONE;
    end
    write_box(lim, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(-10 * ONE, '0, '0, 1'b0);
    send_vertex(-9 * ONE, -10 * ONE, 10 * ONE, 1'b0);
    send_vertex(11 * ONE, -11 * ONE, -11 * ONE, 1'b0);
    // at the limit but short of the tracked point: still replaces
    send_vertex(10 * ONE, 10 * ONE, -10 * ONE, 1'b0);
    send_vertex(-11 * ONE, 9 * ONE, 3 * ONE, 1'b1);
  endtask

  // Box at the coordinate extremes: only the extreme values get through
  task automatic test_closed_box();
    coord_t lim [evs_pkg::NUM_TRACK];
    wait_idle();
    pick_box(BOX_CLOSED, lim);
    write_box(lim, 1'b0);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(MIN_C, MAX_C, '0, 1'b0);
    send_vertex(1 * ONE, 2 * ONE, MAX_C, 1'b1);
  endtask

  // Random meshes under four box settings in turn
  task automatic test_random_meshes(input int n_items);
    coord_t lim [evs_pkg::NUM_TRACK];
    int     sent;
    int     n;
    for (int sub = 0; sub < 4; sub++) begin
      wait_idle();
      pick_box(box_mode_e'(box_rotor % BOX_MODES), lim);
      box_rotor++;
      write_box(lim, $urandom_range(1));
      sent = 0;
      while (sent < n_items / 4) begin
        n = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        send_mesh(n);
        sent += n;
      end
    end
  endtask

  // Long receiver hold-off while short meshes keep coming, then drain
  task automatic test_backpressure();
    wait_idle();
    hold_req <= hold_req + 1;
    for (int m = 0; m < 16; m++) send_mesh(2);
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    snd_idle_pct = 13;
    rcv_idle_pct <= 66;
    test_single_vertex();
    test_open_box();
    test_axis_ties();
    test_box_limits();
    test_closed_box();
    test_random_meshes(104);

    wait_idle();
    snd_idle_pct = 66;
    rcv_idle_pct <= 13;
    test_random_meshes(104);

    wait_idle();
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    test_random_meshes(104);
    test_backpressure();

    wait_idle();
    if (mismatch_cnt == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/evs_pkg.sv
src/evs_tracker.sv
src/extreme_vertex_selector.sv
src/evs_checker.sv
dv/tb.sv
